// File: design/ssdf_pkg.sv
`default_nettype none

package ssdf_pkg;

  localparam int NUM_W = 27;
  localparam int DOT_W = 8;
  localparam int SEL_W = 8;
  localparam int HALF_W = 14;

  // floor(n / 10000) = (n * DIV10K_MUL) >> DIV10K_SHIFT for every 27-bit n
  localparam logic [26:0] DIV10K_MUL = 27'd109951163;
  localparam int DIV10K_SHIFT = 40;
  localparam logic [26:0] TEN_K = 27'd10000;

  // floor(v / 10) = (v * DIV10_MUL) >> DIV10_SHIFT for every 14-bit v
  localparam logic [11:0] DIV10_MUL = 12'd3277;
  localparam int DIV10_SHIFT = 15;

  localparam logic [7:0] DOT_CLEAR = 8'h7f;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [DOT_W-1:0] point_mask;
  } request_t;

  typedef struct packed {
    logic [7:0]       segments;
    logic [SEL_W-1:0] digit_select;
    logic             last;
  } frame_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'hc0;
      4'd1: code = 8'hf9;
      4'd2: code = 8'ha4;
      4'd3: code = 8'hb0;
      4'd4: code = 8'h99;
      4'd5: code = 8'h92;
      4'd6: code = 8'h82;
      4'd7: code = 8'hf8;
      4'd8: code = 8'h80;
      4'd9: code = 8'h90;
      default: code = 8'hff;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: design/seven_segment_decimal_frames_core.sv
// Channel   Signals                  Beat taken when
// request   start, busy, request     rising edge with start high and busy low
// frame     strobe, frame            rising edge ending the cycle strobe is high
//
// Each request gives DIGITS frames on consecutive cycles, rightmost digit first.
// The digit serialiser peels one decimal digit per cycle and loads the next request
// as the last digit goes out. A request passes stages 2 and 3 and the serialiser before
// its first frame is registered; up to three further requests queue in the front stages.
// Synchronous reset empties every stage; no frame is shown during or straight after it.
// The receiver cannot stall; busy rises only while the front stages are full.
`default_nettype none

module seven_segment_decimal_frames_core #(
  parameter int DIGITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire ssdf_pkg::request_t request,
  output logic                   strobe,
  output ssdf_pkg::frame_t       frame
);

  import ssdf_pkg::*;

  localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [PW-1:0] POS_LAST = PW'(DIGITS - 1);
  localparam logic [PW-1:0] POS_HALF = PW'(3);

  // stage 1: captured request
  logic              v1;
  logic [NUM_W-1:0]  num1;
  logic [DOT_W-1:0]  dot1;
  // stage 2: product for the split by 10000
  logic              v2;
  logic [NUM_W-1:0]  num2;
  logic [DOT_W-1:0]  dot2;
  logic [2*NUM_W-1:0] prod2;
  // stage 3: upper half (number / 10000) and lower four-digit half
  logic              v3;
  logic [HALF_W-1:0] hi3;
  logic [HALF_W-1:0] lo3;
  logic [DOT_W-1:0]  dot3;
  // stage 4: digit serialiser
  logic              ser_act;
  logic [PW-1:0]     pos;
  logic [HALF_W-1:0] cur;
  logic [HALF_W-1:0] hi_hold;
  logic [DOT_W-1:0]  dots;

  logic ser_end, ser_free, rdy1, rdy2, rdy3, accept;
  logic [HALF_W-1:0] hi_calc;
  logic [NUM_W-1:0]  lo_calc;
  logic [HALF_W+DIV10_SHIFT-1:0] q_prod;
  logic [HALF_W-1:0] q;
  logic [HALF_W-1:0] rem_full;
  logic [3:0]        digit;
  logic [7:0]        seg;

  assign ser_end  = (pos == POS_LAST);
  assign ser_free = !ser_act || ser_end;
  assign rdy3     = !v3 || ser_free;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign busy     = !rdy1;
  assign accept   = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      num1 <= request.number;
      dot1 <= request.point_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      num2  <= num1;
      dot2  <= dot1;
      prod2 <= (2*NUM_W)'(num1) * (2*NUM_W)'(DIV10K_MUL);
    end
  end

  assign hi_calc = prod2[DIV10K_SHIFT +: HALF_W];
  assign lo_calc = num2 - NUM_W'(hi_calc) * TEN_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      hi3  <= hi_calc;
      lo3  <= lo_calc[HALF_W-1:0];
      dot3 <= dot2;
    end
  end

  // one decimal digit per cycle from the current half
  assign q_prod   = (HALF_W+DIV10_SHIFT)'(cur) * (HALF_W+DIV10_SHIFT)'(DIV10_MUL);
  assign q        = q_prod[DIV10_SHIFT +: HALF_W];
  assign rem_full = cur - ((q << 3) + (q << 1));
  assign digit    = rem_full[3:0];
  assign seg      = dots[0] ? (seg_code(digit) & DOT_CLEAR) : seg_code(digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_act <= 1'b0;
      pos     <= '0;
    end else if (ser_free) begin
      ser_act <= v3;
      pos     <= '0;
    end else begin
      pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_free) begin
      cur     <= lo3;
      hi_hold <= hi3;
      dots    <= dot3;
    end else begin
      // switch to the upper half after the fourth digit
      cur  <= (pos == POS_HALF) ? hi_hold : q;
      dots <= dots >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ser_act;
    end
  end

  always_ff @(posedge clk) begin
    frame.segments     <= seg;
    frame.digit_select <= SEL_W'(1) << pos;
    frame.last         <= ser_end;
  end

  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $onehot(frame.digit_select))
    else $error("frame select not one-hot");

  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    frame.last && strobe |-> frame.digit_select[DIGITS-1])
    else $error("last frame not on leftmost position");

  a_frames_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !frame.last |=> strobe)
    else $error("frame train broken before leftmost position");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted beat not captured");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
  import ssdf_pkg::*;

  localparam int DIGITS = 8;
  localparam int CYCLE_LIMIT = 200000;
  // active-low digit glyphs, digit 0 in the low byte
  localparam logic [79:0] GLYPHS = {8'h90, 8'h80, 8'hf8, 8'h82, 8'h92,
                                    8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic strobe;
  request_t request = '0;
  frame_t frame;

  frame_t pending_frames[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  seven_segment_decimal_frames_core #(.DIGITS(DIGITS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .frame(frame)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("seven_segment_decimal_frames_core verification failed");
      $finish;
    end
  end

  // Rightmost digit first; digits above the top position fall away.
  function automatic void queue_digit_frames(input logic [NUM_W-1:0] number,
                                             input logic [DOT_W-1:0] dots);
    int unsigned value;
    frame_t f;
    value = 32'(number);
    for (int k = 0; k < DIGITS; k++) begin
      f.segments = GLYPHS[(value % 10) * 8 +: 8];
      if (dots[k]) f.segments = f.segments & DOT_CLEAR;
      f.digit_select = SEL_W'(1) << k;
      f.last = (k == DIGITS - 1);
      pending_frames.push_back(f);
      value = value / 10;
    end
  endfunction

  always @(posedge clk) begin
    frame_t want;
    if (!rst && strobe === 1'b1) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame %h with no request outstanding", frame);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        if (frame.segments !== want.segments) begin
          $error("segments: expected %h, got %h", want.segments, frame.segments);
          errors++;
        end
        if (frame.digit_select !== want.digit_select) begin
          $error("digit_select: expected %h, got %h", want.digit_select,
                 frame.digit_select);
          errors++;
        end
        if (frame.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, frame.last);
          errors++;
        end
      end
    end
  end

  // Leaves start high on return, so a following beat can go out on the next edge.
  task automatic send_request(input logic [NUM_W-1:0] number,
                              input logic [DOT_W-1:0] dots);
    start <= 1'b1;
    request <= '{number: number, point_mask: dots};
    do @(posedge clk); while (busy !== 1'b0);
    queue_digit_frames(number, dots);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      request <= '{number: NUM_W'($urandom), point_mask: DOT_W'($urandom)};
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_paced(input logic [NUM_W-1:0] number, input logic [DOT_W-1:0] dots);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      // some bursts follow straight on
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 13));
    end
    burst_left--;
    send_request(number, dots);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [NUM_W-1:0] random_number();
    int unsigned span;
    span = 10 ** $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0: return NUM_W'($urandom);
      1: return NUM_W'(99999999 - $urandom_range(0, 20));
      default: return NUM_W'($urandom_range(0, span - 1));
    endcase
  endfunction

  task automatic test_directed();
    send_request(27'd0, 8'h00);
    send_request(27'd99999999, 8'hff);
    for (int d = 1; d <= 9; d++) send_request(NUM_W'(d * 11111111), 8'h00);
    send_request(27'd12345678, 8'haa);
    send_request(27'd87654321, 8'h55);
    send_request(27'd1, 8'h80);
    send_request(27'd10000000, 8'h01);
    // wider than eight digits: only the low eight survive
    send_request(27'd100000000, 8'h0f);
    send_request(27'h7ffffff, 8'hf0);
    send_request(27'd123456789, 8'h00);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    for (int i = 0; i < 40; i++) send_request(random_number(), DOT_W'($urandom));
    wait_drained();
  endtask

  task automatic test_pause_until_empty();
    for (int r = 0; r < 4; r++) begin
      for (int i = $urandom_range(1, 5); i > 0; i--)
        send_paced(random_number(), DOT_W'($urandom));
      wait_drained();
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < 330; i++) begin
      send_paced(random_number(), DOT_W'($urandom));
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_back_to_back();
    test_pause_until_empty();
    test_random();
    repeat (2 * DIGITS + 4) @(posedge clk);
    if (pending_frames.size() != 0) begin
      $error("%0d frames never arrived", pending_frames.size());
      errors++;
    end
    if (errors == 0) begin
      $display("seven_segment_decimal_frames_core verification clean");
    end else begin
      $display("seven_segment_decimal_frames_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: seven_segment_decimal_frames_core.f
design/ssdf_pkg.sv
design/seven_segment_decimal_frames_core.sv
bench/tb_top.sv
